// File: hdl/csb_pkg.sv
`default_nettype none
package csb_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W:0] SLOT_COUNT = (SLOT_W + 1)'(SLOTS);

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      ST_STORED   = 2'd0,
      ST_REJECTED = 2'd1,
      ST_POPPED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [7:0]  source;
      logic [15:0] customer;
      logic [31:0] arrival;
   } entry_type;

   typedef struct packed {
      logic         found;
      slot_idx_type idx;
   } scan_type;

   function automatic slot_idx_type next_pos(input slot_idx_type p);
      logic [SLOT_W:0] sum;
      begin
         sum = {1'b0, p} + (SLOT_W + 1)'(1);
         if (sum >= SLOT_COUNT) begin
            sum = '0;
         end
         return sum[SLOT_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// File: hdl/circular_slot_buffer_next_fit_top.sv
`default_nettype none
// Push, empty pop: result registered in the cycle after the request beat; a new request
// every cycle unless the output stalls. Pop: registered slot memory read, then S_READ
// loads the result once the output register is free; no new request is taken meanwhile.
// Synchronous active-high reset clears the occupancy bits, the ring pointer and the
// controller; slot memory contents are not reset.
module circular_slot_buffer_next_fit_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_source_no,
   input  wire logic [15:0] req_customer_no,
   input  wire logic [31:0] req_arrival_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_source_no,
   output logic [15:0]      rsp_out_customer_no,
   output logic [31:0]      rsp_out_arrival_time,
   output logic             rsp_buffer_empty
);

   csb_pkg::fsm_type            state_ff, state_in;
   logic [csb_pkg::SLOTS-1:0]   valid_ff, valid_in;
   csb_pkg::slot_idx_type       ptr_ff, ptr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   csb_pkg::status_type         status_ff, status_in;
   csb_pkg::entry_type          rsp_entry_ff, rsp_entry_in;
   logic                        empty_ff, empty_in;

   csb_pkg::scan_type           scan;
   logic                        wr_en, rd_en;
   csb_pkg::entry_type          wr_data, rd_data;

   csb_scan u_scan (
      .valid  (valid_ff),
      .ptr    (ptr_ff),
      .want   (req_op),
      .result (scan)
   );

   assign wr_data = '{source: req_source_no, customer: req_customer_no,
                      arrival: req_arrival_time};

   csb_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (scan.idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan.idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csb_pkg::S_IDLE;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rsp_entry_ff <= rsp_entry_in;
      empty_ff     <= empty_in;
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rsp_entry_in = rsp_entry_ff;
      empty_in     = empty_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         csb_pkg::S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               if (!req_op) begin
                  rsp_valid_in = 1'b1;
                  if (scan.found) begin
                     wr_en               = 1'b1;
                     valid_in[scan.idx]  = 1'b1;
                     ptr_in              = csb_pkg::next_pos(scan.idx);
                     status_in           = csb_pkg::ST_STORED;
                     rsp_entry_in        = '0;
                  end else begin
                     // full: echo the customer back
                     status_in           = csb_pkg::ST_REJECTED;
                     rsp_entry_in        = wr_data;
                  end
               end else if (scan.found) begin
                  rd_en                  = 1'b1;
                  valid_in[scan.idx]     = 1'b0;
                  ptr_in                 = csb_pkg::next_pos(scan.idx);
                  state_in               = csb_pkg::S_READ;
               end else begin
                  rsp_valid_in           = 1'b1;
                  status_in              = csb_pkg::ST_EMPTY;
                  rsp_entry_in           = '0;
               end
               empty_in = ~|valid_in;
            end
         end
         csb_pkg::S_READ: begin
            // wait for the output register to free up; read data holds
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               status_in    = csb_pkg::ST_POPPED;
               rsp_entry_in = rd_data;
               empty_in     = ~|valid_ff;
               state_in     = csb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = csb_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_out_source_no    = rsp_entry_ff.source;
   assign rsp_out_customer_no  = rsp_entry_ff.customer;
   assign rsp_out_arrival_time = rsp_entry_ff.arrival;
   assign rsp_buffer_empty     = empty_ff;

   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op && (|valid_ff))
         |=> (state_ff == csb_pkg::S_READ) && !rsp_valid_ff)
      else $error("pop of an occupied slot did not enter the read state");

   a_stored_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == csb_pkg::ST_STORED)) |-> !empty_ff)
      else $error("stored beat reports an empty buffer");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == csb_pkg::ST_EMPTY)) |-> empty_ff && (valid_ff == '0))
      else $error("empty pop beat with occupied slots");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == csb_pkg::ST_REJECTED)) |-> (&valid_ff))
      else $error("rejected beat while a slot is free");

endmodule
`default_nettype wire

// File: hdl/csb_slot_ram.sv
`default_nettype none
module csb_slot_ram (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire csb_pkg::slot_idx_type wr_addr,
   input  wire csb_pkg::entry_type   wr_data,
   input  wire logic                 rd_en,
   input  wire csb_pkg::slot_idx_type rd_addr,
   output csb_pkg::entry_type        rd_data
);

   csb_pkg::entry_type mem [csb_pkg::SLOTS];
   csb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/csb_scan.sv
`default_nettype none
module csb_scan (
   input  wire logic [csb_pkg::SLOTS-1:0] valid,
   input  wire csb_pkg::slot_idx_type     ptr,
   input  wire logic                      want,
   output csb_pkg::scan_type              result
);

   always_comb begin
      logic [csb_pkg::SLOT_W:0] pos;
      result = '0;
      // walk backward so the slot nearest the pointer wins
      for (int i = csb_pkg::SLOTS - 1; i >= 0; i--) begin
         pos = {1'b0, ptr} + (csb_pkg::SLOT_W + 1)'(i);
         if (pos >= csb_pkg::SLOT_COUNT) begin
            pos = pos - csb_pkg::SLOT_COUNT;
         end
         if (valid[pos[csb_pkg::SLOT_W-1:0]] == want) begin
            result.found = 1'b1;
            result.idx   = pos[csb_pkg::SLOT_W-1:0];
         end
      end
   end

endmodule
`default_nettype wire

// File: tb/csb_op_pkg.sv
`default_nettype none
package csb_op_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

endpackage
`default_nettype wire

// File: tb/csb_result_checker.sv
`default_nettype none
module csb_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_source_no,
   input  wire logic [15:0] req_customer_no,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [7:0]  rsp_out_source_no,
   input  wire logic [15:0] rsp_out_customer_no,
   input  wire logic [31:0] rsp_out_arrival_time,
   input  wire logic        rsp_buffer_empty,
   output int               mismatch_count,
   output int               outcomes_pending
);

   typedef struct {
      csb_pkg::status_type status;
      logic [7:0]          source;
      logic [15:0]         customer;
      logic [31:0]         arrival;
      logic                empty;
   } outcome_type;

   logic [csb_pkg::SLOTS-1:0] occupied;
   csb_pkg::entry_type        held [csb_pkg::SLOTS];
   csb_pkg::slot_idx_type     ring_pos;
   outcome_type               outcome_q [$];

   function automatic csb_pkg::slot_idx_type wrap_inc(input csb_pkg::slot_idx_type p);
      return (p == csb_pkg::slot_idx_type'(csb_pkg::SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Walk the ring once from the pointer; take the first slot whose occupancy matches.
   function automatic outcome_type apply_customer_op(input logic op, input logic [7:0] src,
                                                     input logic [15:0] cust,
                                                     input logic [31:0] arr);
      outcome_type           o;
      csb_pkg::slot_idx_type p;
      csb_pkg::slot_idx_type hit;
      logic                  found;
      logic                  want_busy;
      int                    k;
      o.source   = '0;
      o.customer = '0;
      o.arrival  = '0;
      want_busy  = (op == csb_op_pkg::OP_POP);
      found      = 1'b0;
      hit        = ring_pos;
      p          = ring_pos;
      for (k = 0; k < csb_pkg::SLOTS; k++) begin
         if (!found && occupied[p] == want_busy) begin
            found = 1'b1;
            hit   = p;
         end
         p = wrap_inc(p);
      end
      if (op == csb_op_pkg::OP_PUSH) begin
         if (found) begin
            occupied[hit]      = 1'b1;
            held[hit].source   = src;
            held[hit].customer = cust;
            held[hit].arrival  = arr;
            ring_pos           = wrap_inc(hit);
            o.status           = csb_pkg::ST_STORED;
         end else begin
            // full: echo the customer back, leave the ring alone
            o.status   = csb_pkg::ST_REJECTED;
            o.source   = src;
            o.customer = cust;
            o.arrival  = arr;
         end
      end else begin
         if (found) begin
            o.source      = held[hit].source;
            o.customer    = held[hit].customer;
            o.arrival     = held[hit].arrival;
            occupied[hit] = 1'b0;
            ring_pos      = wrap_inc(hit);
            o.status      = csb_pkg::ST_POPPED;
         end else begin
            o.status = csb_pkg::ST_EMPTY;
         end
      end
      o.empty = (occupied == '0);
      return o;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      $error("%s expected %0h actual %0h", field, exp_val, act_val);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         occupied       = '0;
         ring_pos       = '0;
         mismatch_count = 0;
         outcome_q.delete();
      end else begin
         // retire the result beat first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("result beat with no request waiting, status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status != want.status)
                  note_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_out_source_no != want.source)
                  note_mismatch("out_source_no", 32'(want.source), 32'(rsp_out_source_no));
               if (rsp_out_customer_no != want.customer)
                  note_mismatch("out_customer_no", 32'(want.customer),
                                32'(rsp_out_customer_no));
               if (rsp_out_arrival_time != want.arrival)
                  note_mismatch("out_arrival_time", want.arrival, rsp_out_arrival_time);
               if (rsp_buffer_empty != want.empty)
                  note_mismatch("buffer_empty", 32'(want.empty), 32'(rsp_buffer_empty));
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(apply_customer_op(req_op, req_source_no, req_customer_no,
                                                  req_arrival_time));
      end
      outcomes_pending = outcome_q.size();
   end

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = csb_op_pkg::OP_PUSH;
   logic [7:0]  req_source_no = '0;
   logic [15:0] req_customer_no = '0;
   logic [31:0] req_arrival_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_source_no;
   logic [15:0] rsp_out_customer_no;
   logic [31:0] rsp_out_arrival_time;
   logic        rsp_buffer_empty;

   int mismatch_count;
   int outcomes_pending;
   int cycle_count = 0;
   int send_idle_pct = 24;
   int rsp_idle_pct = 72;

   circular_slot_buffer_next_fit_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_source_no        (req_source_no),
      .req_customer_no      (req_customer_no),
      .req_arrival_time     (req_arrival_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_out_source_no    (rsp_out_source_no),
      .rsp_out_customer_no  (rsp_out_customer_no),
      .rsp_out_arrival_time (rsp_out_arrival_time),
      .rsp_buffer_empty     (rsp_buffer_empty)
   );

   csb_result_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_source_no        (req_source_no),
      .req_customer_no      (req_customer_no),
      .req_arrival_time     (req_arrival_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_out_source_no    (rsp_out_source_no),
      .rsp_out_customer_no  (rsp_out_customer_no),
      .rsp_out_arrival_time (rsp_out_arrival_time),
      .rsp_buffer_empty     (rsp_buffer_empty),
      .mismatch_count       (mismatch_count),
      .outcomes_pending     (outcomes_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one request beat and hold it until accepted; valid drops only on a chosen gap.
   task automatic send_op(input logic op, input logic [7:0] src, input logic [15:0] cust,
                          input logic [31:0] arr);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_source_no    <= src;
      req_customer_no  <= cust;
      req_arrival_time <= arr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(negedge clock); while (outcomes_pending != 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int          i;
      int          push_bias;
      logic [7:0]  src;
      logic [15:0] cust;
      logic [31:0] arr;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pop on a fresh buffer, extremes, wrap-around pop, fill, reject, drain
      send_op(csb_op_pkg::OP_POP, 8'hff, 16'hffff, 32'hffff_ffff);
      send_op(csb_op_pkg::OP_PUSH, 8'h00, 16'h0000, 32'h0000_0000);
      send_op(csb_op_pkg::OP_PUSH, 8'hff, 16'hffff, 32'hffff_ffff);
      send_op(csb_op_pkg::OP_POP, 8'h5a, 16'ha5a5, 32'h1234_5678);
      for (i = 0; i < 8; i++)
         send_op(csb_op_pkg::OP_PUSH, 8'(i * 37 + 1), 16'(i * 4099 + 3),
                 32'(i) * 32'h2468_ace1 + 32'h8000);
      send_op(csb_op_pkg::OP_PUSH, 8'hff, 16'hffff, 32'hffff_ffff);
      send_op(csb_op_pkg::OP_POP, 8'h00, 16'h0000, 32'h0000_0000);
      send_op(csb_op_pkg::OP_POP, 8'haa, 16'h5555, 32'hdead_beef);
      send_op(csb_op_pkg::OP_PUSH, 8'h81, 16'h8001, 32'h8000_0001);
      for (i = 0; i < 9; i++)
         send_op(csb_op_pkg::OP_POP, 8'(i), 16'(i), 32'(i));
      send_op(csb_op_pkg::OP_PUSH, 8'h00, 16'h0000, 32'h0000_0000);

      push_bias = 50;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 72;
            rsp_idle_pct  = 24;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         if (i == RANDOM_ITEMS / 2)
            drain_results();
         // swing between filling and emptying so full and empty both recur
         if (i % 16 == 0)
            push_bias = 20 + 30 * int'($urandom_range(2));
         src  = 8'($urandom_range(255));
         cust = 16'($urandom_range(65535));
         arr  = $urandom();
         if ($urandom_range(15) == 0)
            arr = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
         send_op(($urandom_range(99) < push_bias) ? csb_op_pkg::OP_PUSH : csb_op_pkg::OP_POP,
                 src, cust, arr);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outcomes_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
